[rtl/mvb_pkg.sv]
// ----------------------------------------------------------------------------
// mvb_pkg
// Shared types and constants for the bitmap to vertical-byte converter.
// ----------------------------------------------------------------------------
package mvb_pkg;

    localparam int BYTE_W        = 8;
    localparam int BAND_ROWS     = 8;
    // Earlier rows of a band kept per byte position (last row arrives live)
    localparam int STORE_W       = (BAND_ROWS - 1) * BYTE_W;
    localparam int BAND_W        = BAND_ROWS * BYTE_W;

    localparam logic [7:0] HEADER_MAGIC = 8'h03;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LINE   = 2'd2;

    localparam logic [8:0] RST_WIDTH  = 9'd160;
    localparam logic [6:0] RST_HEIGHT = 7'd43;
    localparam logic [5:0] RST_LINE   = 6'd32;

    // One input byte's worth of work handed to the output sequencer
    typedef struct packed {
        logic              hdr;    // first byte of frame: send header first
        logic [3:0]        ncol;   // visible columns in this byte, 0..8
        logic              flast;  // byte holds the frame's last column
        logic [BAND_W-1:0] band;   // band rows, row r in bits 8r+7:8r
    } item_t;

endpackage

[rtl/mono_bitmap_to_vertical_bytes.sv]
// ----------------------------------------------------------------------------
// mono_bitmap_to_vertical_bytes
// Row-major 1bpp frame bytes in, vertical-byte display message out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ stream: one byte of pixels per transfer, rows in order, line_bytes
//   bytes per row, bit k = column offset k. m_ stream: message bytes; tlast
//   marks the last result of one input byte, tuser[0] the frame's last byte.
//   The first byte of a frame yields a 32-byte header (0x03, zeros) ahead of
//   its own results. Bytes in the last row of a band (8 rows, fewer at frame
//   end) yield one byte per visible column they cover; the rest are only stored.
//   Earlier band rows sit in a 56-bit wide RAM, one word per byte position,
//   read on accept and written back as the byte leaves the stage (forwarded
//   when the next byte hits the same word).
//   A byte passes the read-modify-write stage and then the output sequencer.
//   Throughput: 1 byte per cycle while no results are due; a byte with
//   results waits until the single output port has sent the last result of
//   the byte ahead.
//   Reset: position goes to row 0, byte 0; registers to 160/43/32. Band RAM
//   is not cleared; every stored row is written before it is used.
//   A write to a mapped register restarts the frame. When m_tready is low
//   the current result holds; bytes that are only stored keep flowing, and
//   the first byte with results waits in the pipeline and stalls the input.
// ----------------------------------------------------------------------------
module mono_bitmap_to_vertical_bytes #(
    parameter int MAX_LINE_BYTES = 32,
    parameter int MAX_ROWS       = 64,
    parameter int HEADER_BYTES   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel bytes in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] pixel_byte
    // message bytes out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] out_byte
    output logic        m_tlast,     // run_last
    output logic [0:0]  m_tuser      // [0] frame_last
);
    import mvb_pkg::*;

    localparam int XW  = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int LBW = $clog2(MAX_LINE_BYTES + 1);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int HW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = (LBW + 3 > 9) ? LBW + 3 : 9;

    // ---------------- configuration ----------------
    logic [8:0]  cfg_width_reg;
    logic [6:0]  cfg_height_reg;
    logic [5:0]  cfg_line_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT ||
                                cfg_idx == REG_LINE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= RST_WIDTH;
            cfg_height_reg <= RST_HEIGHT;
            cfg_line_reg   <= RST_LINE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WIDTH:  cfg_width_reg  <= pwdata[8:0];
                REG_HEIGHT: cfg_height_reg <= pwdata[6:0];
                REG_LINE:   cfg_line_reg   <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = 32'(cfg_width_reg);
            REG_HEIGHT: prdata = 32'(cfg_height_reg);
            REG_LINE:   prdata = 32'(cfg_line_reg);
            default:    prdata = 32'd0;
        endcase
    end

    // effective (clamped) geometry
    logic [LBW-1:0] eff_lb;
    logic [HW-1:0]  eff_h;
    logic [CW-1:0]  eff_w;
    logic [CW-1:0]  w_lim;

    always_comb begin
        if (cfg_line_reg == 6'd0) begin
            eff_lb = LBW'(1);
        end else if (32'(cfg_line_reg) > MAX_LINE_BYTES) begin
            eff_lb = LBW'(MAX_LINE_BYTES);
        end else begin
            eff_lb = LBW'(cfg_line_reg);
        end

        if (cfg_height_reg == 7'd0) begin
            eff_h = HW'(1);
        end else if (32'(cfg_height_reg) > MAX_ROWS) begin
            eff_h = HW'(MAX_ROWS);
        end else begin
            eff_h = HW'(cfg_height_reg);
        end

        w_lim = CW'(eff_lb) << 3;
        eff_w = (cfg_width_reg == 9'd0) ? CW'(1) : CW'(cfg_width_reg);
        if (eff_w > w_lim) begin
            eff_w = w_lim;
        end
    end

    // ---------------- position and input stage ----------------
    logic [XW-1:0] x_reg;
    logic [RW-1:0] row_reg;

    logic          accept;
    logic          x_last;
    logic          row_last;
    logic [2:0]    band_b;
    logic          band_end;
    logic          hdr_now;
    logic [CW-1:0] col0;
    logic [CW-1:0] col_span;
    logic [3:0]    ncol_a;
    logic          flast_a;

    assign accept   = s_tvalid && s_tready;
    assign x_last   = (LBW'(x_reg) + LBW'(1)) == eff_lb;
    assign row_last = (HW'(row_reg) + HW'(1)) == eff_h;
    assign band_b   = row_reg[2:0];
    assign band_end = (band_b == 3'd7) || row_last;
    assign hdr_now  = (row_reg == '0) && (x_reg == '0);
    assign col0     = CW'(x_reg) << 3;
    assign col_span = eff_w - col0;

    always_comb begin
        if (!band_end || col0 >= eff_w) begin
            ncol_a = 4'd0;
        end else if (col_span > CW'(8)) begin
            ncol_a = 4'd8;
        end else begin
            ncol_a = col_span[3:0];
        end
    end

    assign flast_a = row_last && (ncol_a != 4'd0) && (col0 + CW'(ncol_a) == eff_w);

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            x_reg   <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (x_last) begin
                x_reg   <= '0;
                row_reg <= row_last ? '0 : row_reg + RW'(1);
            end else begin
                x_reg <= x_reg + XW'(1);
            end
        end
    end

    // ---------------- read-modify-write stage ----------------
    logic                s1_valid_reg;
    logic [7:0]          s1_pix_reg;
    logic [2:0]          s1_b_reg;
    logic [XW-1:0]       s1_x_reg;
    logic                s1_band_end_reg;
    logic                s1_hdr_reg;
    logic [3:0]          s1_ncol_reg;
    logic                s1_flast_reg;

    logic                fwd_reg;
    logic                fwd_next;
    logic [STORE_W-1:0]  fwd_data_reg;

    logic [STORE_W-1:0]  ram_rdata;
    logic [STORE_W-1:0]  old_word;
    logic [BAND_W-1:0]   old_band;
    logic [STORE_W-1:0]  wr_word;
    logic [BAND_W-1:0]   col_band;
    logic                ram_we;
    logic                s1_has_out;
    logic                s1_adv;
    logic                em_ready;
    logic                em_load;
    item_t               em_item;

    assign s1_has_out = s1_hdr_reg || (s1_ncol_reg != 4'd0);
    assign s1_adv     = s1_valid_reg && (!s1_has_out || em_ready);
    assign s_tready   = !s1_valid_reg || s1_adv;
    assign em_load    = s1_adv && s1_has_out;
    assign ram_we     = s1_adv && !s1_band_end_reg;

    assign old_word = fwd_reg ? fwd_data_reg : ram_rdata;
    assign old_band = {8'h00, old_word};

    always_comb begin
        for (int r = 0; r < BAND_ROWS - 1; r++) begin
            wr_word[r*BYTE_W +: BYTE_W] = (3'(r) == s1_b_reg) ? s1_pix_reg
                                                              : old_band[r*BYTE_W +: BYTE_W];
        end
        // rows above the current one belong to an older band: masked off
        for (int r = 0; r < BAND_ROWS; r++) begin
            if (3'(r) < s1_b_reg) begin
                col_band[r*BYTE_W +: BYTE_W] = old_band[r*BYTE_W +: BYTE_W];
            end else if (3'(r) == s1_b_reg) begin
                col_band[r*BYTE_W +: BYTE_W] = s1_pix_reg;
            end else begin
                col_band[r*BYTE_W +: BYTE_W] = 8'h00;
            end
        end
    end

    assign em_item.hdr   = s1_hdr_reg;
    assign em_item.ncol  = s1_ncol_reg;
    assign em_item.flast = s1_flast_reg;
    assign em_item.band  = col_band;

    // next byte reads the word being written back in the same cycle
    always_comb begin
        if (accept) begin
            fwd_next = ram_we && (s1_x_reg == x_reg);
        end else if (s1_adv) begin
            fwd_next = 1'b0;
        end else begin
            fwd_next = fwd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            fwd_reg <= fwd_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg      <= s_tdata;
            s1_b_reg        <= band_b;
            s1_x_reg        <= x_reg;
            s1_band_end_reg <= band_end;
            s1_hdr_reg      <= hdr_now;
            s1_ncol_reg     <= ncol_a;
            s1_flast_reg    <= flast_a;
            fwd_data_reg    <= wr_word;
        end
    end

    mvb_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_LINE_BYTES)
    ) u_band_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_x_reg),
        .wdata (wr_word),
        .re    (accept),
        .raddr (x_reg),
        .rdata (ram_rdata)
    );

    mvb_emit #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (em_load),
        .item     (em_item),
        .ready    (em_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_fwd_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> s1_valid_reg)
        else $error("forward flag set with no item in flight");

    a_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        LBW'(x_reg) < eff_lb)
        else $error("byte position beyond line length");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        HW'(row_reg) < eff_h)
        else $error("row position beyond frame height");

    a_frame_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame end not on last result of its byte");

endmodule

[rtl/mvb_ram.sv]
// ----------------------------------------------------------------------------
// mvb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mvb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/mvb_emit.sv]
// ----------------------------------------------------------------------------
// mvb_emit
// Output sequencer: plays out the header and the column bytes of one item.
// ----------------------------------------------------------------------------
module mvb_emit #(
    parameter int HEADER_BYTES = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  mvb_pkg::item_t item,
    output logic          ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,    // [7:0] out_byte
    output logic          m_tlast,    // run_last
    output logic [0:0]    m_tuser     // [0] frame_last
);
    import mvb_pkg::*;

    localparam int HCW = $clog2(HEADER_BYTES + 1);

    logic              valid_reg;
    logic [HCW-1:0]    hdr_left_reg;
    logic [3:0]        col_reg;
    logic [3:0]        ncol_reg;
    logic              flast_reg;
    logic [BAND_W-1:0] band_reg;

    logic              hdr_beat;
    logic              last_beat;
    logic              xfer;
    logic              done;
    logic [7:0]        col_byte;

    assign hdr_beat  = (hdr_left_reg != '0);
    assign last_beat = hdr_beat ? (hdr_left_reg == HCW'(1) && ncol_reg == 4'd0)
                                : (col_reg + 4'd1 == ncol_reg);
    assign xfer      = valid_reg && m_tready;
    assign done      = xfer && last_beat;
    assign ready     = !valid_reg || done;

    // transpose: bit r of the column byte is row r at this column
    always_comb begin
        for (int r = 0; r < BAND_ROWS; r++) begin
            col_byte[r] = band_reg[r*BYTE_W + int'(col_reg[2:0])];
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = hdr_beat ? ((hdr_left_reg == HCW'(HEADER_BYTES)) ? HEADER_MAGIC : 8'h00)
                                 : col_byte;
    assign m_tlast    = last_beat;
    assign m_tuser[0] = !hdr_beat && flast_reg && last_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            hdr_left_reg <= '0;
            col_reg      <= 4'd0;
        end else if (load) begin
            valid_reg    <= 1'b1;
            hdr_left_reg <= item.hdr ? HCW'(HEADER_BYTES) : '0;
            col_reg      <= 4'd0;
        end else if (done) begin
            valid_reg    <= 1'b0;
        end else if (xfer) begin
            if (hdr_beat) begin
                hdr_left_reg <= hdr_left_reg - HCW'(1);
            end else begin
                col_reg <= col_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ncol_reg  <= item.ncol;
            flast_reg <= item.flast;
            band_reg  <= item.band;
        end
    end

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !hdr_beat |-> col_reg < ncol_reg)
        else $error("column beat beyond item width");

    a_hdr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_left_reg <= HCW'(HEADER_BYTES))
        else $error("header count out of range");

    a_done_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        done && !load |=> !valid_reg)
        else $error("sequencer still busy after final transfer");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the bitmap to vertical-byte converter. Pixel bytes go in on the
// s_ stream, and a local model of the band store and frame position predicts
// every message byte and its tlast/tuser flags. Message bytes are compared in
// order as they leave on the m_ stream. Registers are set over APB between
// phases. Both streams idle at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mvb_pkg::*;

    localparam int LINE_BYTES_MAX  = 32;
    localparam int ROWS_MAX        = 64;
    localparam int HEADER_LEN      = 32;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int RANDOM_TARGET   = 300;
    localparam int PRINT_LIMIT     = 40;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_last;
    } msg_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;      // [7:0] pixel_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] out_byte
    logic        m_tlast;            // run_last
    logic [0:0]  m_tuser;            // [0] frame_last

    // model state
    logic [8:0]  cfg_width  = RST_WIDTH;
    logic [6:0]  cfg_height = RST_HEIGHT;
    logic [5:0]  cfg_line   = RST_LINE;
    logic [STORE_W-1:0] band_rows [LINE_BYTES_MAX];
    int unsigned cur_row  = 0;
    int unsigned cur_byte = 0;
    msg_byte_t   due_bytes [$];

    int unsigned fail_count   = 0;
    int unsigned results_seen = 0;
    int unsigned stall_cycles = 0;
    bit          no_idle      = 1'b0;
    bit          hold_off_req = 1'b0;
    bit          holding      = 1'b0;

    mono_bitmap_to_vertical_bytes #(
        .MAX_LINE_BYTES (LINE_BYTES_MAX),
        .MAX_ROWS       (ROWS_MAX),
        .HEADER_BYTES   (HEADER_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned eff_line(input logic [5:0] lb);
        if (lb == 0) return 1;
        if (lb > LINE_BYTES_MAX) return LINE_BYTES_MAX;
        return lb;
    endfunction

    function automatic int unsigned eff_rows(input logic [6:0] h);
        if (h == 0) return 1;
        if (h > ROWS_MAX) return ROWS_MAX;
        return h;
    endfunction

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] random_pixels();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom());
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) $display("mismatch: %s", what);
    endtask

    task automatic apply_register(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            REG_WIDTH:  cfg_width  = data[8:0];
            REG_HEIGHT: cfg_height = data[6:0];
            REG_LINE:   cfg_line   = data[5:0];
            default:    return;
        endcase
        cur_row  = 0;
        cur_byte = 0;
    endtask

    // Expected message bytes for one accepted pixel byte
    task automatic predict_columns(input logic [7:0] pix);
        int unsigned lb, h, w, x, b, col, k, r;
        bit          band_end;
        logic [7:0]  v;
        msg_byte_t   batch [$];
        msg_byte_t   one;
        lb = eff_line(cfg_line);
        h  = eff_rows(cfg_height);
        w  = (cfg_width == 0) ? 1 : cfg_width;
        if (w > 8 * lb) w = 8 * lb;
        if (cur_row >= h || cur_byte >= lb) begin
            cur_row  = 0;
            cur_byte = 0;
        end
        x = cur_byte;
        b = cur_row & 7;
        band_end = (b == 7) || (cur_row + 1 == h);
        if (cur_row == 0 && x == 0) begin
            for (k = 0; k < HEADER_LEN; k++) begin
                one = '{out_byte: (k == 0) ? HEADER_MAGIC : 8'h00,
                        run_last: 1'b0, frame_last: 1'b0};
                batch.push_back(one);
            end
        end
        if (!band_end) begin
            band_rows[x][8*b +: 8] = pix;
        end else begin
            for (k = 0; k < 8; k++) begin
                col = x * 8 + k;
                if (col >= w) break;
                v = '0;
                for (r = 0; r < b; r++) v[r] = band_rows[x][8*r + k];
                v[b] = pix[k];
                one = '{out_byte: v, run_last: 1'b0,
                        frame_last: (cur_row + 1 == h) && (col + 1 == w)};
                batch.push_back(one);
            end
        end
        if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
        foreach (batch[i]) due_bytes.push_back(batch[i]);
        cur_byte++;
        if (cur_byte >= lb) begin
            cur_byte = 0;
            cur_row++;
            if (cur_row >= h) cur_row = 0;
        end
    endtask

    // Prediction, checking and stall watchdog, all sampled at the clock edge
    always @(posedge aclk) begin : scoreboard
        msg_byte_t want;
        bit        moved;
        if (aresetn) begin
            moved = 1'b0;
            if (psel && penable && pwrite && pready) begin
                apply_register(paddr[3:2], pwdata);
                moved = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                predict_columns(s_tdata);
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (due_bytes.size() == 0) begin
                    report_mismatch($sformatf("transfer %0d: result with nothing expected",
                                              results_seen));
                end else begin
                    want = due_bytes.pop_front();
                    if (m_tdata !== want.out_byte)
                        report_mismatch($sformatf("transfer %0d: out_byte %02h, want %02h",
                                                  results_seen, m_tdata, want.out_byte));
                    if (m_tlast !== want.run_last)
                        report_mismatch($sformatf("transfer %0d: tlast %b, want %b",
                                                  results_seen, m_tlast, want.run_last));
                    if (m_tuser[0] !== want.frame_last)
                        report_mismatch($sformatf("transfer %0d: frame_last %b, want %b",
                                                  results_seen, m_tuser[0],
                                                  want.frame_last));
                end
                results_seen++;
            end
            if (moved) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // Result side: random ready, steady ready, or one long hold-off on request
    initial begin : result_sink
        int span;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                holding      = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                holding      = 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                span = idle_span();
                if (span > 0) begin
                    m_tready <= 1'b0;
                    repeat (span) @(posedge aclk);
                end
                m_tready <= 1'b1;
                span = $urandom_range(1, 8);
                repeat (span) @(posedge aclk);
            end
        end
    end

    // Offer one pixel byte and return at the edge that takes it; valid stays
    // up so that a following call can chain without a bubble.
    task automatic push_pixel_byte(input logic [7:0] pix);
        int gap;
        gap = no_idle ? 0 : idle_span();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_bytes.size() != 0) @(posedge aclk);
        // stored-only bytes may still be in flight
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_field(input logic [1:0] idx, input logic [31:0] val, input int fw);
        apb_write(idx, ($urandom() << fw) | val);
    endtask

    // Upper bits of each write are random; only the field bits matter
    task automatic configure(input logic [8:0] w, input logic [6:0] h,
                             input logic [5:0] lb);
        wait_drained();
        apply_field(REG_WIDTH, w, 9);
        apply_field(REG_HEIGHT, h, 7);
        apply_field(REG_LINE, lb, 6);
    endtask

    task automatic test_reset_defaults();
        push_pixel_byte(8'hA5);
        push_pixel_byte(8'h5A);
    endtask

    // zero registers count as one: every byte is a whole one-pixel frame
    task automatic test_single_pixel_frame();
        configure(9'd0, 7'd0, 6'd0);
        push_pixel_byte(8'hFF);
        push_pixel_byte(8'hFE);
        push_pixel_byte(8'h01);
    endtask

    // three-row frame ends its only band early; unmapped write mid-frame
    task automatic test_short_last_band();
        configure(9'd12, 7'd3, 6'd2);
        push_pixel_byte(8'hFF);
        push_pixel_byte(8'h00);
        push_pixel_byte(8'hAA);
        wait_drained();
        apb_write(REG_UNMAPPED, $urandom());
        push_pixel_byte(8'h55);
        push_pixel_byte(8'h0F);
        push_pixel_byte(8'hF0);
        push_pixel_byte(8'h3C);
    endtask

    task automatic test_padding_bytes();
        configure(9'd5, 7'd2, 6'd3);
        push_pixel_byte(8'hFF);
        push_pixel_byte(8'hFF);
        push_pixel_byte(8'h81);
        push_pixel_byte(8'h0A);
        push_pixel_byte(8'hFF);
        push_pixel_byte(8'h7E);
    endtask

    task automatic test_register_saturation();
        configure(9'd511, 7'd127, 6'd63);
        push_pixel_byte(8'hC3);
        push_pixel_byte(8'h3C);
    endtask

    task automatic test_restart_mid_frame();
        configure(9'd16, 7'd8, 6'd2);
        push_pixel_byte(8'h12);
        push_pixel_byte(8'h34);
        push_pixel_byte(8'h56);
        push_pixel_byte(8'h78);
        configure(9'd16, 7'd8, 6'd2);
        push_pixel_byte(8'h9A);
        push_pixel_byte(8'hBC);
    endtask

    // output held off while input keeps coming: pipeline fills, input stalls
    task automatic test_backpressure();
        configure(9'd64, 7'd2, 6'd8);
        no_idle      = 1'b1;
        hold_off_req = 1'b1;
        wait (holding);
        repeat (48) push_pixel_byte(random_pixels());
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_frames();
        int unsigned sent, n, probe_at, frame, i;
        logic [8:0]  w;
        logic [6:0]  h;
        logic [5:0]  lb;
        sent = 0;
        while (sent < RANDOM_TARGET) begin
            case ($urandom_range(0, 9))
                0: begin
                    // widest rows, one or two rows per frame
                    lb = 6'($urandom_range(32, 63));
                    h  = 7'($urandom_range(0, 2));
                    w  = ($urandom_range(0, 1) == 0) ? 9'd256 : 9'($urandom_range(257, 511));
                end
                1: begin
                    // tallest frames, one byte per row
                    lb = 6'($urandom_range(0, 1));
                    h  = 7'($urandom_range(64, 127));
                    w  = 9'($urandom_range(0, 16));
                end
                default: begin
                    lb = 6'($urandom_range(1, 4));
                    h  = 7'($urandom_range(1, 20));
                    w  = 9'($urandom_range(0, 8 * lb + 4));
                end
            endcase
            configure(w, h, lb);
            no_idle = ($urandom_range(0, 3) == 0);
            frame = eff_line(lb) * eff_rows(h);
            n = frame + $urandom_range(0, frame);
            if (n > 140) n = 140;
            probe_at = (n > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, n - 1) : 0;
            for (i = 0; i < n; i++) begin
                if (probe_at != 0 && i == probe_at) begin
                    wait_drained();
                    apb_write(REG_UNMAPPED, $urandom());
                end
                push_pixel_byte(random_pixels());
            end
            sent += n;
        end
        no_idle = 1'b0;
    endtask

    initial begin : main_sequence
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_single_pixel_frame();
        test_short_last_band();
        test_padding_bytes();
        test_register_saturation();
        test_restart_mid_frame();
        test_backpressure();
        test_random_frames();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (due_bytes.size() != 0) report_mismatch("expected results never arrived");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
